[design/dapd_pkg.sv]
// Shared widths, register indexes and drive helper functions for the dual-axis PD drive.
package dapd_pkg;

  localparam int POS_W  = 16;  // encoder position and speed
  localparam int TGT_W  = 8;   // signed target speed
  localparam int GAIN_W = 8;   // gains and override multiplier
  localparam int LIM_W  = 11;  // drive limit, dead band and duty
  localparam int DRV_W  = 12;  // accumulated drive, signed
  localparam int SIL_W  = 16;  // silence count and limit
  localparam int SUM_W  = 26;  // exact drive sum before the clamp
  localparam int CFG_W  = 16;  // widest register
  localparam int IDX_W  = 3;   // register index

  // Register indexes
  localparam logic [IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN_A  = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN_B  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEAD_BAND     = 3'd4;
  localparam logic [IDX_W-1:0] REG_SILENCE_LIMIT = 3'd5;
  localparam logic [IDX_W-1:0] REG_OVERRIDE_GAIN = 3'd6;

  // Reset values
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN     = 8'd8;
  localparam logic [GAIN_W-1:0] RST_DERIV_GAIN_A  = 8'd12;
  localparam logic [GAIN_W-1:0] RST_DERIV_GAIN_B  = 8'd7;
  localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT   = 11'd1200;
  localparam logic [LIM_W-1:0]  RST_DEAD_BAND     = 11'd100;
  localparam logic [SIL_W-1:0]  RST_SILENCE_LIMIT = 16'd10;
  localparam logic [GAIN_W-1:0] RST_OVERRIDE_GAIN = 8'd9;

  // Saturate an exact sum to +/- lim
  function automatic logic signed [DRV_W-1:0] clamp_drive(
    input logic signed [SUM_W-1:0] v,
    input logic [LIM_W-1:0]        lim
  );
    logic signed [SUM_W-1:0] lim_s;
    lim_s = SUM_W'($signed({1'b0, lim}));
    if (v > lim_s) begin
      return DRV_W'(lim_s);
    end else if (v < -lim_s) begin
      return DRV_W'(-lim_s);
    end else begin
      return v[DRV_W-1:0];
    end
  endfunction

  // Duty magnitude of a clamped drive
  function automatic logic [LIM_W-1:0] drive_mag(input logic signed [DRV_W-1:0] d);
    logic signed [DRV_W-1:0] a;
    a = d[DRV_W-1] ? -d : d;
    return a[LIM_W-1:0];
  endfunction

  // Direction bit: held when the drive is zero
  function automatic logic next_dir(input logic signed [DRV_W-1:0] d, input logic dir);
    if (d == '0) begin
      return dir;
    end else begin
      return d[DRV_W-1];
    end
  endfunction

endpackage

[design/dapd_axis.sv]
// One axis of the PD update: wrapped speed, slope and the exact unclamped drive sum.
module dapd_axis (
  input  logic [dapd_pkg::POS_W-1:0]         position,
  input  logic [dapd_pkg::POS_W-1:0]         last_position,
  input  logic signed [dapd_pkg::POS_W-1:0]  last_speed,
  input  logic signed [dapd_pkg::TGT_W-1:0]  target,
  input  logic signed [dapd_pkg::DRV_W-1:0]  drive,
  input  logic [dapd_pkg::GAIN_W-1:0]        prop_gain,
  input  logic [dapd_pkg::GAIN_W-1:0]        deriv_gain,
  output logic signed [dapd_pkg::POS_W-1:0]  speed,
  output logic signed [dapd_pkg::SUM_W-1:0]  drive_sum
);

  logic signed [dapd_pkg::POS_W-1:0] slope;
  logic signed [dapd_pkg::POS_W:0]   err;
  logic signed [dapd_pkg::SUM_W-1:0] prop_term;
  logic signed [dapd_pkg::SUM_W-1:0] deriv_term;

  // Speed and slope wrap to 16 bits
  assign speed = $signed(position - last_position);
  assign slope = speed - last_speed;

  // Speed error is exact
  assign err = (dapd_pkg::POS_W+1)'(target) - (dapd_pkg::POS_W+1)'(speed);

  // Proportional and derivative products
  assign prop_term  = dapd_pkg::SUM_W'($signed({1'b0, prop_gain})) * dapd_pkg::SUM_W'(err);
  assign deriv_term = dapd_pkg::SUM_W'($signed({1'b0, deriv_gain})) * dapd_pkg::SUM_W'(slope);

  assign drive_sum = dapd_pkg::SUM_W'(drive) + prop_term - deriv_term;

endmodule

[design/dual_axis_velocity_pd_drive.sv]
// Top level of the dual-axis incremental PD velocity drive.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one control tick: two encoder
//   positions, two signed target speeds and two silence counts.
//   Output channel (out_valid/out_ready) returns one word per tick: duty and
//   direction for each axis, the measured axis A speed and the axis A drive
//   before the update. Registers are written through cfg_we/cfg_index/cfg_data;
//   the user must write them only while idle, which the block does not enforce.
// Timing:
//   A tick is captured into an input register, computed combinationally and
//   written to the result register together with the axis state; one tick is
//   taken every cycle while out_ready is high. The state feedback (drive, last
//   position, last speed) closes combinationally from the state registers.
// Reset: all state, both direction bits and registers return to their
//   defaults; both channels come up empty.
// Stall: when out_ready is low the result register holds, the input register
//   still fills, and in_ready drops only when both are occupied.
module dual_axis_velocity_pd_drive (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [dapd_pkg::IDX_W-1:0]          cfg_index,
  input  logic [dapd_pkg::CFG_W-1:0]          cfg_data,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dapd_pkg::POS_W-1:0]          position_a,
  input  logic [dapd_pkg::POS_W-1:0]          position_b,
  input  logic signed [dapd_pkg::TGT_W-1:0]   target_a,
  input  logic signed [dapd_pkg::TGT_W-1:0]   target_b,
  input  logic [dapd_pkg::SIL_W-1:0]          silence_a,
  input  logic [dapd_pkg::SIL_W-1:0]          silence_b,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dapd_pkg::LIM_W-1:0]          duty_a,
  output logic                                reverse_a,
  output logic [dapd_pkg::LIM_W-1:0]          duty_b,
  output logic                                reverse_b,
  output logic signed [dapd_pkg::POS_W-1:0]   speed_a,
  output logic signed [dapd_pkg::DRV_W-1:0]   prior_drive_a
);

  // Registers
  logic [dapd_pkg::GAIN_W-1:0] prop_gain, deriv_gain_a, deriv_gain_b, override_gain;
  logic [dapd_pkg::LIM_W-1:0]  drive_limit, dead_band;
  logic [dapd_pkg::SIL_W-1:0]  silence_limit;

  // Input register
  logic                               in_full;
  logic [dapd_pkg::POS_W-1:0]         pos_a_q, pos_b_q;
  logic signed [dapd_pkg::TGT_W-1:0]  tgt_a_q, tgt_b_q;
  logic [dapd_pkg::SIL_W-1:0]         sil_a_q, sil_b_q;

  // Axis state
  logic [dapd_pkg::POS_W-1:0]         last_position_a, last_position_b;
  logic signed [dapd_pkg::POS_W-1:0]  last_speed_a, last_speed_b;
  logic signed [dapd_pkg::DRV_W-1:0]  drive_a, drive_b;
  logic                               direction_a, direction_b;

  // Compute stage
  logic                               advance;
  logic signed [dapd_pkg::POS_W-1:0]  spd_a, spd_b;
  logic signed [dapd_pkg::SUM_W-1:0]  sum_a, sum_b;
  logic signed [dapd_pkg::SUM_W-1:0]  na, dead_s, ovr;
  logic signed [dapd_pkg::SUM_W-1:0]  nb;
  logic signed [dapd_pkg::DRV_W-1:0]  drive_a_next, drive_b_next;
  logic                               direction_a_next, direction_b_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= dapd_pkg::RST_PROP_GAIN;
      deriv_gain_a  <= dapd_pkg::RST_DERIV_GAIN_A;
      deriv_gain_b  <= dapd_pkg::RST_DERIV_GAIN_B;
      drive_limit   <= dapd_pkg::RST_DRIVE_LIMIT;
      dead_band     <= dapd_pkg::RST_DEAD_BAND;
      silence_limit <= dapd_pkg::RST_SILENCE_LIMIT;
      override_gain <= dapd_pkg::RST_OVERRIDE_GAIN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dapd_pkg::REG_PROP_GAIN:     prop_gain     <= cfg_data[dapd_pkg::GAIN_W-1:0];
        dapd_pkg::REG_DERIV_GAIN_A:  deriv_gain_a  <= cfg_data[dapd_pkg::GAIN_W-1:0];
        dapd_pkg::REG_DERIV_GAIN_B:  deriv_gain_b  <= cfg_data[dapd_pkg::GAIN_W-1:0];
        dapd_pkg::REG_DRIVE_LIMIT:   drive_limit   <= cfg_data[dapd_pkg::LIM_W-1:0];
        dapd_pkg::REG_DEAD_BAND:     dead_band     <= cfg_data[dapd_pkg::LIM_W-1:0];
        dapd_pkg::REG_SILENCE_LIMIT: silence_limit <= cfg_data[dapd_pkg::SIL_W-1:0];
        dapd_pkg::REG_OVERRIDE_GAIN: override_gain <= cfg_data[dapd_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: compute when the input register holds a word and the result slot frees
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_a_q <= position_a;
      pos_b_q <= position_b;
      tgt_a_q <= target_a;
      tgt_b_q <= target_b;
      sil_a_q <= silence_a;
      sil_b_q <= silence_b;
    end
  end

  // Per-axis PD sums
  dapd_axis u_axis_a (
    .position      (pos_a_q),
    .last_position (last_position_a),
    .last_speed    (last_speed_a),
    .target        (tgt_a_q),
    .drive         (drive_a),
    .prop_gain     (prop_gain),
    .deriv_gain    (deriv_gain_a),
    .speed         (spd_a),
    .drive_sum     (sum_a)
  );

  dapd_axis u_axis_b (
    .position      (pos_b_q),
    .last_position (last_position_b),
    .last_speed    (last_speed_b),
    .target        (tgt_b_q),
    .drive         (drive_b),
    .prop_gain     (prop_gain),
    .deriv_gain    (deriv_gain_b),
    .speed         (spd_b),
    .drive_sum     (sum_b)
  );

  // Axis A: dead band, override by target_b, silence cut-off
  assign dead_s = dapd_pkg::SUM_W'($signed({1'b0, dead_band}));
  assign ovr    = dapd_pkg::SUM_W'(tgt_b_q) *
                  dapd_pkg::SUM_W'($signed({1'b0, override_gain}));

  always_comb begin
    na = sum_a;
    if (tgt_a_q == '0 && sum_a < dead_s && sum_a > -dead_s) begin
      na = '0;
    end
    if (tgt_b_q != '0) begin
      na = ovr;
    end
    if (sil_a_q > silence_limit) begin
      na = '0;
    end
  end

  // Axis B: silence cut-off only
  assign nb = (sil_b_q > silence_limit) ? '0 : sum_b;

  assign drive_a_next     = dapd_pkg::clamp_drive(na, drive_limit);
  assign drive_b_next     = dapd_pkg::clamp_drive(nb, drive_limit);
  assign direction_a_next = dapd_pkg::next_dir(drive_a_next, direction_a);
  assign direction_b_next = dapd_pkg::next_dir(drive_b_next, direction_b);

  // Axis state update
  always_ff @(posedge clk) begin
    if (rst) begin
      last_position_a <= '0;
      last_position_b <= '0;
      last_speed_a    <= '0;
      last_speed_b    <= '0;
      drive_a         <= '0;
      drive_b         <= '0;
      direction_a     <= 1'b0;
      direction_b     <= 1'b0;
    end else if (advance) begin
      last_position_a <= pos_a_q;
      last_position_b <= pos_b_q;
      last_speed_a    <= spd_a;
      last_speed_b    <= spd_b;
      drive_a         <= drive_a_next;
      drive_b         <= drive_b_next;
      direction_a     <= direction_a_next;
      direction_b     <= direction_b_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_a        <= dapd_pkg::drive_mag(drive_a_next);
      reverse_a     <= direction_a_next;
      duty_b        <= dapd_pkg::drive_mag(drive_b_next);
      reverse_b     <= direction_b_next;
      speed_a       <= spd_a;
      prior_drive_a <= drive_a;
    end
  end

`ifndef SYNTH
  // A computed duty never exceeds the limit in force
  a_duty_limit: assert property (@(posedge clk) disable iff (rst)
    advance |=> (duty_a <= $past(drive_limit)) && (duty_b <= $past(drive_limit)))
    else $error("duty exceeds drive limit");

  // Duty and direction of axis A follow the stored drive
  a_duty_matches_drive: assert property (@(posedge clk) disable iff (rst)
    advance |=> (duty_a == dapd_pkg::drive_mag(drive_a)) && (reverse_a == direction_a))
    else $error("axis A result disagrees with stored drive");

  // On axis B, zero duty keeps the previous direction
  a_dir_held: assert property (@(posedge clk) disable iff (rst)
    advance |=> (duty_b != '0) || (reverse_b == $past(direction_b)))
    else $error("axis B direction changed on zero drive");

  // A silent axis A encoder forces zero drive on axis A
  a_silence_cut: assert property (@(posedge clk) disable iff (rst)
    (advance && sil_a_q > silence_limit) |=> (duty_a == '0) && (drive_a == '0))
    else $error("axis A not cut off on silence");

  // A held input word is not lost while the result slot is blocked
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> in_full)
    else $error("stalled input word dropped");
`endif

endmodule
